### hdl/opmt_pkg.sv
// Shared constants, command codes and controller/datapath interface types for the MAC tile.
package opmt_pkg;

	localparam int LANES         = 4;
	localparam int IDX_W         = 2;
	localparam int CMD_W         = 2;
	localparam int OPND_W        = 16;
	localparam int PROD_W        = 2 * OPND_W;
	localparam int ACC_W         = 48;
	localparam int DEF_TILE_ROWS = 4;
	localparam int DEF_TILE_COLS = 4;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MAC   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;

	typedef struct packed {
		logic             load_en;
		logic             mac_en;
		logic             emit;
		logic [IDX_W-1:0] emit_row;
		logic [IDX_W-1:0] emit_col;
		logic             emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
	} dp_stat_t;

endpackage

### hdl/opmt_ctrl.sv
// Controller: command decode, drain sequencing and input handshake.
module opmt_ctrl
	import opmt_pkg::*;
#(
	parameter int TILE_ROWS = DEF_TILE_ROWS,
	parameter int TILE_COLS = DEF_TILE_COLS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] command,
	input  logic [IDX_W-1:0] row_index,
	input  logic [IDX_W-1:0] col_index,
	output dp_cmd_t          dp_cmd,
	input  dp_stat_t         dp_stat
);

	localparam int ROWS_USED = (TILE_ROWS < LANES) ? TILE_ROWS : LANES;
	localparam int COLS_USED = (TILE_COLS < LANES) ? TILE_COLS : LANES;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	logic             accept;
	logic             row_end;
	logic             col_end;
	logic             in_tile;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign row_end  = (row_q == IDX_W'(ROWS_USED - 1));
	assign col_end  = (col_q == IDX_W'(COLS_USED - 1));
	// ignore loads that fall outside the active tile
	assign in_tile  = ({1'b0, row_index} < (IDX_W+1)'(ROWS_USED)) &&
		({1'b0, col_index} < (IDX_W+1)'(COLS_USED));

	always_comb begin
		dp_cmd           = '0;
		dp_cmd.load_en   = accept && (command == CMD_LOAD) && in_tile;
		dp_cmd.mac_en    = accept && (command == CMD_MAC);
		dp_cmd.emit      = (state_q == ST_DRAIN) && dp_stat.slot_free;
		dp_cmd.emit_row  = row_q;
		dp_cmd.emit_col  = col_q;
		dp_cmd.emit_last = row_end && col_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					row_q <= '0;
					col_q <= '0;
					if (accept && (command == CMD_DRAIN)) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (dp_stat.slot_free) begin
						if (col_end) begin
							col_q <= '0;
							if (row_end) begin
								row_q   <= '0;
								state_q <= ST_IDLE;
							end else begin
								row_q <= row_q + 1'b1;
							end
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hdl/opmt_dp.sv
// Datapath: product stage, saturating accumulators and output register.
module opmt_dp
	import opmt_pkg::*;
#(
	parameter int TILE_ROWS = DEF_TILE_ROWS,
	parameter int TILE_COLS = DEF_TILE_COLS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  dp_cmd,
	output dp_stat_t                 dp_stat,
	input  logic [IDX_W-1:0]         row_index,
	input  logic [IDX_W-1:0]         col_index,
	input  logic signed [ACC_W-1:0]  c_value,
	input  logic signed [OPND_W-1:0] a_row0,
	input  logic signed [OPND_W-1:0] a_row1,
	input  logic signed [OPND_W-1:0] a_row2,
	input  logic signed [OPND_W-1:0] a_row3,
	input  logic signed [OPND_W-1:0] b_col0,
	input  logic signed [OPND_W-1:0] b_col1,
	input  logic signed [OPND_W-1:0] b_col2,
	input  logic signed [OPND_W-1:0] b_col3,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [IDX_W-1:0]         out_row,
	output logic [IDX_W-1:0]         out_col,
	output logic signed [ACC_W-1:0]  sum_value,
	output logic                     last_of_tile
);

	localparam int ROWS_USED = (TILE_ROWS < LANES) ? TILE_ROWS : LANES;
	localparam int COLS_USED = (TILE_COLS < LANES) ? TILE_COLS : LANES;

	logic signed [OPND_W-1:0] a_lane [LANES];
	logic signed [OPND_W-1:0] b_lane [LANES];
	logic [ACC_W-1:0]         acc_w  [LANES*LANES];

	logic                     load_s1;
	logic                     mac_s1;
	logic [IDX_W-1:0]         ld_row_s1;
	logic [IDX_W-1:0]         ld_col_s1;
	logic [ACC_W-1:0]         cval_s1;

	logic                     out_valid_q;
	logic [IDX_W-1:0]         out_row_q;
	logic [IDX_W-1:0]         out_col_q;
	logic [ACC_W-1:0]         sum_q;
	logic                     last_q;

	assign a_lane[0] = a_row0;
	assign a_lane[1] = a_row1;
	assign a_lane[2] = a_row2;
	assign a_lane[3] = a_row3;
	assign b_lane[0] = b_col0;
	assign b_lane[1] = b_col1;
	assign b_lane[2] = b_col2;
	assign b_lane[3] = b_col3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_s1 <= 1'b0;
			mac_s1  <= 1'b0;
		end else begin
			load_s1 <= dp_cmd.load_en;
			mac_s1  <= dp_cmd.mac_en;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load_en) begin
			ld_row_s1 <= row_index;
			ld_col_s1 <= col_index;
			cval_s1   <= c_value;
		end
	end

	for (genvar r = 0; r < LANES; r++) begin : g_row
		for (genvar c = 0; c < LANES; c++) begin : g_col
			if (r < ROWS_USED && c < COLS_USED) begin : g_used
				logic signed [PROD_W-1:0] prod_s1;
				logic [ACC_W-1:0]         acc_q;
				logic [ACC_W:0]           sum_w;
				logic [ACC_W-1:0]         sat_w;

				always_ff @(posedge clk) begin
					if (dp_cmd.mac_en) prod_s1 <= a_lane[r] * b_lane[c];
				end

				assign sum_w = {acc_q[ACC_W-1], acc_q} +
					{{(ACC_W+1-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};

				// clamp when the two top bits of the widened sum disagree
				always_comb begin
					if (sum_w[ACC_W] != sum_w[ACC_W-1])
						sat_w = sum_w[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} :
							{1'b0, {(ACC_W-1){1'b1}}};
					else
						sat_w = sum_w[ACC_W-1:0];
				end

				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						acc_q <= '0;
					end else if (load_s1 && ld_row_s1 == IDX_W'(r) &&
							ld_col_s1 == IDX_W'(c)) begin
						acc_q <= cval_s1;
					end else if (mac_s1) begin
						acc_q <= sat_w;
					end
				end

				assign acc_w[r*LANES + c] = acc_q;
			end else begin : g_unused
				assign acc_w[r*LANES + c] = '0;
			end
		end
	end

	assign dp_stat.slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.emit) begin
			out_row_q <= dp_cmd.emit_row;
			out_col_q <= dp_cmd.emit_col;
			sum_q     <= acc_w[{dp_cmd.emit_row, dp_cmd.emit_col}];
			last_q    <= dp_cmd.emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_row      = out_row_q;
	assign out_col      = out_col_q;
	assign sum_value    = sum_q;
	assign last_of_tile = last_q;

endmodule

### hdl/outer_product_mac_tile_4x4_core.sv
// Top level of the outer-product multiply-accumulate tile.
// Keeps a TILE_ROWS x TILE_COLS tile of signed Q18.30 accumulators (at most
// 4 x 4). A load transfer writes one element, a multiply-accumulate transfer
// adds all A x B slice products with saturation, and a drain transfer emits
// the tile in row-major order, flagging the final element. Load and MAC
// transfers are registered (load value or product register) before the
// accumulator write (the saturating add for MAC); back-to-back transfers are
// accepted every cycle while no drain is active. A drain holds off the input
// until the tile is emitted, one element per cycle through the single output
// register while the consumer is ready. Draining leaves the accumulators intact.
module outer_product_mac_tile_4x4_core
	import opmt_pkg::*;
#(
	parameter int TILE_ROWS = DEF_TILE_ROWS,
	parameter int TILE_COLS = DEF_TILE_COLS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         command,
	input  logic [IDX_W-1:0]         row_index,
	input  logic [IDX_W-1:0]         col_index,
	input  logic signed [ACC_W-1:0]  c_value,
	input  logic signed [OPND_W-1:0] a_row0,
	input  logic signed [OPND_W-1:0] a_row1,
	input  logic signed [OPND_W-1:0] a_row2,
	input  logic signed [OPND_W-1:0] a_row3,
	input  logic signed [OPND_W-1:0] b_col0,
	input  logic signed [OPND_W-1:0] b_col1,
	input  logic signed [OPND_W-1:0] b_col2,
	input  logic signed [OPND_W-1:0] b_col3,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [IDX_W-1:0]         out_row,
	output logic [IDX_W-1:0]         out_col,
	output logic signed [ACC_W-1:0]  sum_value,
	output logic                     last_of_tile
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	opmt_ctrl #(
		.TILE_ROWS(TILE_ROWS),
		.TILE_COLS(TILE_COLS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.row_index(row_index),
		.col_index(col_index),
		.dp_cmd   (dp_cmd),
		.dp_stat  (dp_stat)
	);

	opmt_dp #(
		.TILE_ROWS(TILE_ROWS),
		.TILE_COLS(TILE_COLS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.dp_stat     (dp_stat),
		.row_index   (row_index),
		.col_index   (col_index),
		.c_value     (c_value),
		.a_row0      (a_row0),
		.a_row1      (a_row1),
		.a_row2      (a_row2),
		.a_row3      (a_row3),
		.b_col0      (b_col0),
		.b_col1      (b_col1),
		.b_col2      (b_col2),
		.b_col3      (b_col3),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_row     (out_row),
		.out_col     (out_col),
		.sum_value   (sum_value),
		.last_of_tile(last_of_tile)
	);

endmodule

### tb/sv/outer_product_mac_tile_4x4_core_tb.sv
// Testbench for the outer-product MAC tile: random and directed transfers, sums checked in order.
`timescale 1ns / 100ps

module outer_product_mac_tile_4x4_core_tb;
	import opmt_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_MIN = -SUM_MAX - 1;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [CMD_W-1:0]             cmd;
		logic [IDX_W-1:0]             row;
		logic [IDX_W-1:0]             col;
		logic [ACC_W-1:0]             c_val;
		logic [LANES-1:0][OPND_W-1:0] a_lane;
		logic [LANES-1:0][OPND_W-1:0] b_lane;
	} tile_op_t;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [ACC_W-1:0] sum;
		logic             last;
	} tile_sum_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [CMD_W-1:0]         command = '0;
	logic [IDX_W-1:0]         row_index = '0;
	logic [IDX_W-1:0]         col_index = '0;
	logic signed [ACC_W-1:0]  c_value = '0;
	logic signed [OPND_W-1:0] a_row0 = '0;
	logic signed [OPND_W-1:0] a_row1 = '0;
	logic signed [OPND_W-1:0] a_row2 = '0;
	logic signed [OPND_W-1:0] a_row3 = '0;
	logic signed [OPND_W-1:0] b_col0 = '0;
	logic signed [OPND_W-1:0] b_col1 = '0;
	logic signed [OPND_W-1:0] b_col2 = '0;
	logic signed [OPND_W-1:0] b_col3 = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;
	logic signed [ACC_W-1:0]  sum_value;
	logic                     last_of_tile;

	logic signed [ACC_W-1:0] tile_acc [LANES*LANES];
	tile_sum_t               pending_sums [$];
	int                      n_fail = 0;
	int                      items_sent = 0;
	int                      src_idle_pct = 0;
	int                      snk_idle_pct = 0;
	int                      hold_off_cycles = 0;

	outer_product_mac_tile_4x4_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.row_index    (row_index),
		.col_index    (col_index),
		.c_value      (c_value),
		.a_row0       (a_row0),
		.a_row1       (a_row1),
		.a_row2       (a_row2),
		.a_row3       (a_row3),
		.b_col0       (b_col0),
		.b_col1       (b_col1),
		.b_col2       (b_col2),
		.b_col3       (b_col3),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_row      (out_row),
		.out_col      (out_col),
		.sum_value    (sum_value),
		.last_of_tile (last_of_tile)
	);

	always #2 clk = ~clk;

	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		for (int i = 0; i < LANES*LANES; i++)
			tile_acc[i] = '0;
	end

	function automatic logic signed [ACC_W-1:0] sat_accumulate(input logic signed [ACC_W-1:0] acc,
			input longint prod);
		longint s;
		s = longint'(acc) + prod;
		if (s > SUM_MAX)
			s = SUM_MAX;
		else if (s < SUM_MIN)
			s = SUM_MIN;
		return s[ACC_W-1:0];
	endfunction

	// Advance the tile model by one accepted transfer; a drain queues sixteen sums.
	task automatic update_tile(input tile_op_t op);
		longint prod;
		tile_sum_t s;
		case (op.cmd)
			CMD_LOAD: tile_acc[op.row*LANES + op.col] = op.c_val;
			CMD_MAC: begin
				for (int r = 0; r < LANES; r++)
					for (int c = 0; c < LANES; c++) begin
						prod = longint'($signed(op.a_lane[r])) * longint'($signed(op.b_lane[c]));
						tile_acc[r*LANES + c] = sat_accumulate(tile_acc[r*LANES + c], prod);
					end
			end
			CMD_DRAIN: begin
				for (int i = 0; i < LANES*LANES; i++) begin
					s.row  = IDX_W'(i / LANES);
					s.col  = IDX_W'(i % LANES);
					s.sum  = tile_acc[i];
					s.last = (i == LANES*LANES - 1);
					pending_sums.push_back(s);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin : track_transfers
		tile_op_t op;
		if (arst_n && in_valid && in_ready) begin
			op.cmd    = command;
			op.row    = row_index;
			op.col    = col_index;
			op.c_val  = c_value;
			op.a_lane = {a_row3, a_row2, a_row1, a_row0};
			op.b_lane = {b_col3, b_col2, b_col1, b_col0};
			update_tile(op);
		end
	end

	always @(posedge clk) begin : check_sums
		tile_sum_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_sums.size() == 0) begin
				n_fail++;
				if (n_fail <= MAX_REPORTS)
					$display("unexpected sum: row %0d col %0d sum %0d last %0b",
						out_row, out_col, sum_value, last_of_tile);
			end else begin
				want = pending_sums.pop_front();
				if (out_row !== want.row || out_col !== want.col ||
						sum_value !== $signed(want.sum) || last_of_tile !== want.last) begin
					n_fail++;
					if (n_fail <= MAX_REPORTS)
						$display("sum mismatch: exp row %0d col %0d sum %0d last %0b, got row %0d col %0d sum %0d last %0b",
							want.row, want.col, $signed(want.sum), want.last,
							out_row, out_col, sum_value, last_of_tile);
				end
			end
		end
	end

	// Receiver: a requested hold-off wins over the random stall pattern.
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			out_ready <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	function automatic logic [OPND_W-1:0] rand_opnd();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return OPND_W'($urandom_range(0, 255));
			default: return OPND_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [LANES-1:0][OPND_W-1:0] rand_lanes();
		logic [LANES-1:0][OPND_W-1:0] v;
		for (int i = 0; i < LANES; i++)
			v[i] = rand_opnd();
		return v;
	endfunction

	function automatic logic [ACC_W-1:0] rand_c_value();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: return SUM_MAX[ACC_W-1:0];
			1: return SUM_MIN[ACC_W-1:0];
			2: return SUM_MAX[ACC_W-1:0] - ACC_W'(raw[31:0]);
			3: return SUM_MIN[ACC_W-1:0] + ACC_W'(raw[31:0]);
			4: return '0;
			default: return raw[ACC_W-1:0];
		endcase
	endfunction

	function automatic tile_op_t rand_op(input logic [CMD_W-1:0] cmd);
		tile_op_t op;
		op.cmd    = cmd;
		op.row    = IDX_W'($urandom_range(0, 3));
		op.col    = IDX_W'($urandom_range(0, 3));
		op.c_val  = rand_c_value();
		op.a_lane = rand_lanes();
		op.b_lane = rand_lanes();
		return op;
	endfunction

	// Offer one transfer after a random idle gap and hold it until accepted.
	task automatic send_op(input tile_op_t op);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		command   <= op.cmd;
		row_index <= op.row;
		col_index <= op.col;
		c_value   <= op.c_val;
		a_row0    <= op.a_lane[0];
		a_row1    <= op.a_lane[1];
		a_row2    <= op.a_lane[2];
		a_row3    <= op.a_lane[3];
		b_col0    <= op.b_lane[0];
		b_col1    <= op.b_lane[1];
		b_col2    <= op.b_lane[2];
		b_col3    <= op.b_lane[3];
		in_valid  <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	task automatic send_load(input int row, input int col, input logic [ACC_W-1:0] val);
		tile_op_t op;
		op = rand_op(CMD_LOAD);
		op.row = IDX_W'(row);
		op.col = IDX_W'(col);
		op.c_val = val;
		send_op(op);
	endtask

	task automatic send_mac(input logic [LANES-1:0][OPND_W-1:0] a,
			input logic [LANES-1:0][OPND_W-1:0] b);
		tile_op_t op;
		op = rand_op(CMD_MAC);
		op.a_lane = a;
		op.b_lane = b;
		send_op(op);
	endtask

	// Drop valid and hold until every queued sum has been emitted.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed();
		send_op(rand_op(CMD_DRAIN));
		send_load(0, 0, SUM_MAX[ACC_W-1:0]);
		send_load(0, 1, SUM_MIN[ACC_W-1:0]);
		send_load(3, 3, SUM_MAX[ACC_W-1:0]);
		send_load(2, 1, SUM_MIN[ACC_W-1:0]);
		send_load(1, 2, 48'h5555_5555_5555);
		send_load(2, 2, 48'hAAAA_AAAA_AAAA);
		// row 0 col 0 pushes past the top, row 0 col 1 past the bottom
		send_mac({16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000},
			{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000});
		send_op(rand_op(CMD_UNUSED));
		send_op(rand_op(CMD_DRAIN));
		send_op(rand_op(CMD_DRAIN));
		send_mac({4{16'h8000}}, {4{16'h8000}});
		send_mac({4{16'h7FFF}}, {4{16'h8000}});
		send_mac({4{16'h7FFF}}, {4{16'h7FFF}});
		send_op(rand_op(CMD_UNUSED));
		send_op(rand_op(CMD_DRAIN));
	endtask

	// Mostly well-formed tiles: loads, a run of MAC steps, a drain; some noise mixed in.
	task automatic test_random_tiles(input int n_items);
		int stop_at;
		int mode;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			mode = $urandom_range(0, 9);
			if (mode < 5) begin
				for (int r = 0; r < LANES; r++)
					for (int c = 0; c < LANES; c++)
						send_load(r, c, (mode == 0) ? '0 : rand_c_value());
			end else if (mode < 8) begin
				repeat ($urandom_range(1, 6))
					send_op(rand_op(CMD_LOAD));
			end
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 9) == 0)
					send_op(rand_op(CMD_LOAD + CMD_W'($urandom_range(0, 3))));
				send_mac(rand_lanes(), rand_lanes());
			end
			if ($urandom_range(0, 9) != 0)
				send_op(rand_op(CMD_DRAIN));
		end
	endtask

	// Starve the output long enough that drains back up into the input.
	task automatic test_output_stall();
		int saved_idle;
		saved_idle = src_idle_pct;
		src_idle_pct = 0;
		hold_off_cycles <= 300;
		send_op(rand_op(CMD_DRAIN));
		repeat (15)
			send_mac(rand_lanes(), rand_lanes());
		send_op(rand_op(CMD_DRAIN));
		repeat (15)
			send_op(rand_op(CMD_LOAD));
		send_op(rand_op(CMD_DRAIN));
		src_idle_pct = saved_idle;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		src_idle_pct = 24;
		snk_idle_pct = 84;
		test_directed();
		test_random_tiles(100);
		test_output_stall();

		src_idle_pct = 84;
		snk_idle_pct = 24;
		test_random_tiles(100);
		wait_idle();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_tiles(100);
		wait_idle();

		if (n_fail == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
